@@ sv/fll_pkg.sv @@
// ---------------------------------------------------------------------------
// fll_pkg
// shared constants and types of the falling level logger
// ---------------------------------------------------------------------------
package fll_pkg;

  localparam int MAX_RECORDS = 200;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int REC_W       = 16;

  localparam logic [7:0] MAX_REC_B      = 8'(MAX_RECORDS);
  localparam logic [7:0] TICKS_RESET    = 8'd4;
  localparam logic [7:0] LEVEL_RESET    = 8'hff;
  localparam logic [7:0] FRAME_END_BYTE = 8'hff;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // source of the frame byte of a result
  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_COUNT,
    SEL_HI,
    SEL_LO,
    SEL_END
  } fll_sel_t;

  // per item control passed from update stage to output stage
  typedef struct packed {
    fll_sel_t   sel;
    logic       recorded;
    logic [7:0] count;
    logic       full;
  } fll_meta_t;

endpackage

@@ sv/fll_ram.sv @@
// ---------------------------------------------------------------------------
// fll_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module fll_ram #(
  parameter int DEPTH = 200,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/fll_ctrl.sv @@
// ---------------------------------------------------------------------------
// fll_ctrl
// prescaler, elapsed counter, minimum tracking and store addressing
// ---------------------------------------------------------------------------
module fll_ctrl import fll_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  logic              op,
  input  logic [9:0]        sample,
  input  logic [8:0]        read_index,
  output fll_meta_t         meta,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [REC_W-1:0]  wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr
);

  logic [7:0] ticks_r;
  logic [7:0] prescale_r, prescale_nxt;
  logic [7:0] elapsed_r, elapsed_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] last_r, last_nxt;

  logic [7:0] period;
  logic [7:0] level;
  logic [7:0] elapsed_inc;
  logic       wrap;
  logic       rec;
  logic [9:0] idx_w;
  logic [9:0] two_n;
  logic [8:0] idx_m1;

  assign period      = (ticks_r == 8'd0) ? 8'd1 : ticks_r;
  assign level       = sample[9:2];
  assign elapsed_inc = elapsed_r + 8'd1;
  assign wrap        = (op == OP_TICK) && (prescale_r >= period - 8'd1);
  assign rec         = wrap && (count_r < MAX_REC_B) && (level < last_r);

  assign idx_w  = {1'b0, read_index};
  assign two_n  = {1'b0, count_r, 1'b0};
  assign idx_m1 = read_index - 9'd1;

  always_comb begin
    prescale_nxt = prescale_r;
    elapsed_nxt  = elapsed_r;
    count_nxt    = count_r;
    last_nxt     = last_r;
    if (op == OP_TICK) begin
      if (wrap) begin
        prescale_nxt = 8'd0;
        elapsed_nxt  = elapsed_inc;
        if (rec) begin
          count_nxt   = count_r + 8'd1;
          last_nxt    = level;
          elapsed_nxt = 8'd0;
        end
      end else begin
        prescale_nxt = prescale_r + 8'd1;
      end
    end
  end

  // frame byte source for read items, plus record flag, count and full flag
  always_comb begin
    meta.sel = SEL_ZERO;
    if (op == OP_READ) begin
      if (idx_w == 10'd0) begin
        meta.sel = SEL_COUNT;
      end else if (idx_w <= two_n) begin
        meta.sel = idx_m1[0] ? SEL_LO : SEL_HI;
      end else if (idx_w == two_n + 10'd1) begin
        meta.sel = SEL_END;
      end
    end
    meta.recorded = rec;
    meta.count    = count_nxt;
    meta.full     = (count_nxt >= MAX_REC_B);
  end

  assign wr_en   = accept && rec;
  assign wr_addr = count_r[ADDR_W-1:0];
  assign wr_data = {elapsed_inc, level};
  assign rd_en   = accept && (op == OP_READ);
  assign rd_addr = idx_m1[ADDR_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= TICKS_RESET;
      prescale_r <= 8'd0;
      elapsed_r  <= 8'd0;
      count_r    <= 8'd0;
      last_r     <= LEVEL_RESET;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_data;
      end
      if (accept) begin
        prescale_r <= prescale_nxt;
        elapsed_r  <= elapsed_nxt;
        count_r    <= count_nxt;
        last_r     <= last_nxt;
      end
    end
  end

endmodule

@@ sv/fll_out.sv @@
// ---------------------------------------------------------------------------
// fll_out
// read data stage and output register with stall handling
// ---------------------------------------------------------------------------
module fll_out import fll_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  fll_meta_t        meta,
  input  logic [REC_W-1:0] rd_data,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_read_byte,
  output logic             out_recorded,
  output logic [7:0]       out_record_count,
  output logic             out_full_res
);

  logic      s1_valid_r;
  fll_meta_t s1_meta_r;
  logic      s1_adv;
  logic      out_valid_r;
  logic [7:0] byte_nxt;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign out_valid = out_valid_r;

  always_comb begin
    case (s1_meta_r.sel)
      SEL_ZERO:  byte_nxt = 8'd0;
      SEL_COUNT: byte_nxt = s1_meta_r.count;
      SEL_HI:    byte_nxt = rd_data[15:8];
      SEL_LO:    byte_nxt = rd_data[7:0];
      SEL_END:   byte_nxt = FRAME_END_BYTE;
      default:   byte_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv && s1_valid_r) begin
      out_read_byte    <= byte_nxt;
      out_recorded     <= s1_meta_r.recorded;
      out_record_count <= s1_meta_r.count;
      out_full_res     <= s1_meta_r.full;
    end
  end

endmodule

@@ sv/falling_level_logger_top.sv @@
// ---------------------------------------------------------------------------
// falling_level_logger_top
// logs each new minimum of a prescaled level into a record ram and serves
// the dump frame one byte per read item
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   in_      | input     | in_valid / in_stall | operation, sample, read_index
//   out_     | output    | out_valid/out_stall | read_byte, recorded,
//            |           |                     | record_count, full_res
//   cfg_     | input     | cfg_valid/cfg_ready | cfg_data = ticks_per_period
//
// one item per cycle while in_stall is low; a taken item passes the ram
// data stage (registered read of the record ram) and then the output register
// rst_n is synchronous; the record ram is not cleared, only written entries
// are ever shown in the frame
// out_stall holds the output register; the ram data stage keeps taking
// items until it is also full, then in_stall rises
// cfg_ready is always high
//
module falling_level_logger_top import fll_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [9:0] in_sample,
  input  logic [8:0] in_read_index,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte,
  output logic       out_recorded,
  output logic [7:0] out_record_count,
  output logic       out_full_res,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic              accept;
  fll_meta_t         meta;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [REC_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [REC_W-1:0]  rd_data;

  // item taken when valid and not stalled
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // scalar state, update and ram addressing
  fll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .op         (in_operation),
    .sample     (in_sample),
    .read_index (in_read_index),
    .meta       (meta),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  // record store: elapsed in high byte, level in low byte
  fll_ram #(
    .DEPTH (MAX_RECORDS),
    .WIDTH (REC_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // byte select and output register
  fll_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .meta             (meta),
    .rd_data          (rd_data),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_byte    (out_read_byte),
    .out_recorded     (out_recorded),
    .out_record_count (out_record_count),
    .out_full_res     (out_full_res)
  );

endmodule
